>>> hw/rtl/wsbp_pkg.sv
// Shared constants and types for the wheel speed balancing PID controller.
package wsbp_pkg;

  // Fixed field widths
  localparam int unsigned SpeedW = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DriveW = 32;
  localparam int unsigned ErrW   = SpeedW + 1;  // sum of two speeds
  localparam int unsigned DpW    = ErrW + 1;    // first difference
  localparam int unsigned DdW    = ErrW + 2;    // second difference
  localparam int unsigned DeltaW = 37;          // |delta| < 7 * 2^32

  localparam int unsigned GainFracBitsDefault = 8;

  // Gain reset values, Q8.8
  localparam logic [GainW-1:0] GainPReset = 16'd640;  // 2.5
  localparam logic [GainW-1:0] GainIReset = 16'd51;   // ~0.2
  localparam logic [GainW-1:0] GainDReset = 16'd384;  // 1.5

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } cfg_reg_e;

endpackage

>>> hw/rtl/wheel_speed_balance_pid.sv
// Top level of the wheel speed balancing incremental PID controller.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one request per control
//   tick: a pair of signed wheel speeds. The wheel of larger magnitude is the
//   target, the other the measured value; on a tie the previous pair is kept.
//   Output channel (out_valid_o / out_ready_i) returns one request per input:
//   the integer part of the PID accumulator and a flag set when it clamped.
//   Gains are written over the plain write port (cfg_we_i, cfg_index_i,
//   cfg_data_i) while the block is idle; unknown indexes are dropped.
// Timing
//   Four register stages: input, error terms, gain products, accumulator and
//   output. After acceptance a request passes the error term, gain product
//   and output registers. One request per cycle is sustained while out_ready_i
//   is high; the error history and the accumulator add-and-clamp are feedback loops.
// Stalls and reset
//   Each stage holds while the one after it is full and stalled, so bubbles
//   still close up and a new request is taken while a result waits. When all
//   stages are full and the receiver stalls, in_ready_o drops.
//   Reset clears the speed and error history, the accumulator and all valid
//   flags, and loads the default gains (2.5, ~0.2, 1.5).
module wheel_speed_balance_pid #(
  parameter int unsigned GAIN_FRAC_BITS = wsbp_pkg::GainFracBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [wsbp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [wsbp_pkg::GainW-1:0]           cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wsbp_pkg::SpeedW-1:0]   speed_a_i,
  input  logic signed [wsbp_pkg::SpeedW-1:0]   speed_b_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [wsbp_pkg::DriveW-1:0]   drive_value_o,
  output logic                                 saturated_o
);

  localparam int unsigned SpeedW = wsbp_pkg::SpeedW;
  localparam int unsigned GainW  = wsbp_pkg::GainW;
  localparam int unsigned ErrW   = wsbp_pkg::ErrW;
  localparam int unsigned DpW    = wsbp_pkg::DpW;
  localparam int unsigned DdW    = wsbp_pkg::DdW;
  localparam int unsigned DeltaW = wsbp_pkg::DeltaW;
  localparam int unsigned DriveW = wsbp_pkg::DriveW;
  localparam int unsigned AccW   = DriveW + GAIN_FRAC_BITS;
  localparam int unsigned SumW   = ((AccW > DeltaW) ? AccW : DeltaW) + 1;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [AccW-1:0] FracMask =
    {{(AccW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  // ---------------------------------------------------------------------
  // Gain registers
  // ---------------------------------------------------------------------
  logic [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic             gains_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= wsbp_pkg::GainPReset;
      gain_i_q <= wsbp_pkg::GainIReset;
      gain_d_q <= wsbp_pkg::GainDReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wsbp_pkg::REG_GAIN_P: gain_p_q <= cfg_data_i;
        wsbp_pkg::REG_GAIN_I: gain_i_q <= cfg_data_i;
        wsbp_pkg::REG_GAIN_D: gain_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign gains_zero = (gain_p_q == '0) && (gain_i_q == '0) && (gain_d_q == '0);

  // ---------------------------------------------------------------------
  // Handshake chain: a stage takes new data when empty or when it empties
  // ---------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_fire, s2_fire, s3_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s3_free    = !s3_valid_q || out_free;
  assign s2_free    = !s2_valid_q || s3_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;

  assign s1_fire = s1_valid_q && s2_free;  // stage 1 -> stage 2
  assign s2_fire = s2_valid_q && s3_free;  // stage 2 -> stage 3
  assign s3_fire = s3_valid_q && out_free; // stage 3 -> output

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) s1_valid_q  <= in_valid_i;
      if (s2_free) s2_valid_q  <= s1_valid_q;
      if (s3_free) s3_valid_q  <= s2_valid_q;
      if (out_free) out_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  logic signed [SpeedW-1:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_a_q <= speed_a_i;
      s1_b_q <= speed_b_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 -> 2: wheel selection, error and its differences
  // ---------------------------------------------------------------------
  logic signed [SpeedW-1:0] target_q, measured_q, target_d, measured_d;
  logic signed [ErrW-1:0]   err_prev_q, err_prev2_q, err_d;
  logic [ErrW-1:0]          mag_a, mag_b;
  logic signed [DpW-1:0]    dp_d, dp_q;
  logic signed [ErrW-1:0]   di_q;
  logic signed [DdW-1:0]    dd_d, dd_q;

  // magnitude of -32768 comes out as 32768, larger than any other
  assign mag_a = s1_a_q[SpeedW-1] ? (ErrW'(0) - {1'b1, s1_a_q}) : {1'b0, s1_a_q};
  assign mag_b = s1_b_q[SpeedW-1] ? (ErrW'(0) - {1'b1, s1_b_q}) : {1'b0, s1_b_q};

  always_comb begin
    target_d   = target_q;
    measured_d = measured_q;
    if (mag_a > mag_b) begin
      target_d   = s1_a_q;
      measured_d = s1_b_q;
    end else if (mag_a < mag_b) begin
      target_d   = s1_b_q;
      measured_d = s1_a_q;
    end
  end

  assign err_d = $signed({target_d[SpeedW-1], target_d})
               + $signed({measured_d[SpeedW-1], measured_d});

  assign dp_d = $signed({err_d[ErrW-1], err_d})
              - $signed({err_prev_q[ErrW-1], err_prev_q});

  assign dd_d = $signed({{2{err_d[ErrW-1]}}, err_d})
              - $signed({err_prev_q[ErrW-1], err_prev_q, 1'b0})
              + $signed({{2{err_prev2_q[ErrW-1]}}, err_prev2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      measured_q  <= '0;
      err_prev_q  <= '0;
      err_prev2_q <= '0;
    end else if (s1_fire) begin
      target_q    <= target_d;
      measured_q  <= measured_d;
      err_prev_q  <= err_d;
      err_prev2_q <= err_prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      dp_q <= dp_d;
      di_q <= err_d;
      dd_q <= dd_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2 -> 3: gain products, one multiplier per term
  // ---------------------------------------------------------------------
  logic signed [DeltaW-1:0] prod_p_d, prod_i_d, prod_d_d;
  logic signed [DeltaW-1:0] prod_p_q, prod_i_q, prod_d_q;

  assign prod_p_d = DeltaW'($signed({1'b0, gain_p_q})) * DeltaW'(dp_q);
  assign prod_i_d = DeltaW'($signed({1'b0, gain_i_q})) * DeltaW'(di_q);
  assign prod_d_d = DeltaW'($signed({1'b0, gain_d_q})) * DeltaW'(dd_q);

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3 -> output: accumulate with clamp
  // ---------------------------------------------------------------------
  logic signed [DeltaW-1:0] delta;
  logic signed [SumW-1:0]   sum;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic                     ovf, sat_d, saturated_q;

  assign delta = prod_p_q + prod_i_q + prod_d_q;
  assign sum   = $signed({{(SumW-AccW){acc_q[AccW-1]}}, acc_q})
               + $signed({{(SumW-DeltaW){delta[DeltaW-1]}}, delta});

  // overflow when the bits above the accumulator's sign differ from it
  assign ovf = (sum[SumW-1:AccW-1] != {(SumW-AccW+1){1'b0}})
            && (sum[SumW-1:AccW-1] != {(SumW-AccW+1){1'b1}});

  always_comb begin
    acc_d = sum[AccW-1:0];
    sat_d = 1'b0;
    if (gains_zero) begin
      acc_d = '0;
    end else if (ovf) begin
      acc_d = sum[SumW-1] ? AccMin : AccMax;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (s3_fire) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_fire) begin
      saturated_q <= sat_d;
    end
  end

  // integer part, truncated toward zero: bias negatives before the shift
  logic [AccW-1:0] acc_biased;

  assign acc_biased    = acc_q + (acc_q[AccW-1] ? FracMask : '0);
  assign drive_value_o = $signed(acc_biased[AccW-1:GAIN_FRAC_BITS]);
  assign saturated_o   = saturated_q;
  assign out_valid_o   = out_valid_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`ifndef SYNTHESIS
  // a clamped result leaves the accumulator at one of its limits
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && saturated_q) |-> ((acc_q == AccMax) || (acc_q == AccMin)))
    else $error("saturated flag without accumulator at a limit");

  // all gains zero clears the accumulator and never clamps
  a_zero_gain_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_fire && gains_zero) |=> ((acc_q == '0) && !saturated_q))
    else $error("zero gains did not clear the accumulator");

  // back-pressure only when every stage holds a request
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q))
    else $error("input stalled with a free stage");
`endif

endmodule
